// File: src/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared constants, codes and types of the ADSR envelope shaper, including the
// elaboration-time build of the log10(1+9x) curve table.
// ----------------------------------------------------------------------------
package adsr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int LOG_DEPTH = 256;
   localparam int LOG_IDX_W = $clog2(LOG_DEPTH);
   localparam int CURVE_W   = FRAC_BITS + 1;

   // curve codes
   localparam logic [2:0] SHAPE_LIN  = 3'd0;
   localparam logic [2:0] SHAPE_SQR  = 3'd1;
   localparam logic [2:0] SHAPE_LOG  = 3'd2;
   localparam logic [2:0] SHAPE_SQRT = 3'd3;
   localparam logic [2:0] SHAPE_NONE = 3'd4;

   // segment codes
   localparam logic [1:0] SEG_ATTACK  = 2'd0;
   localparam logic [1:0] SEG_DECAY   = 2'd1;
   localparam logic [1:0] SEG_SUSTAIN = 2'd2;
   localparam logic [1:0] SEG_RELEASE = 2'd3;

   // register indexes
   localparam logic [7:0] REG_SUSTAIN_LEVEL  = 8'd0;
   localparam logic [7:0] REG_ATTACK_WEIGHT  = 8'd1;
   localparam logic [7:0] REG_DECAY_WEIGHT   = 8'd2;
   localparam logic [7:0] REG_SUSTAIN_WEIGHT = 8'd3;
   localparam logic [7:0] REG_RELEASE_WEIGHT = 8'd4;
   localparam logic [7:0] REG_ATTACK_SHAPE   = 8'd5;
   localparam logic [7:0] REG_DECAY_SHAPE    = 8'd6;
   localparam logic [7:0] REG_RELEASE_SHAPE  = 8'd7;

   typedef struct packed {
      logic [1:0] seg;
      logic [2:0] shape;
   } tag_type;

   typedef logic [CURVE_W-1:0] log_tab_type [0:LOG_DEPTH];

   // log2 with 32 fraction bits by repeated squaring
   function automatic logic [63:0] log2_q32(input logic [63:0] n);
      int k;
      logic [63:0] m;
      logic [63:0] frac;
      logic [63:0] nn;
      k    = 0;
      frac = '0;
      nn   = (n == 64'd0) ? 64'd1 : n;
      for (int i = 0; i < 62; i++) begin
         if ((nn >> (i + 1)) != 64'd0) k = i + 1;
      end
      m = (k <= 30) ? (nn << (30 - k)) : (nn >> (k - 30));
      for (int i = 0; i < 32; i++) begin
         m    = (m * m) >> 30;
         frac = {frac[62:0], 1'b0};
         if (m >= (64'd2 << 30)) begin
            m       = m >> 1;
            frac[0] = 1'b1;
         end
      end
      return (64'(k) << 32) | frac;
   endfunction

   // point i = log10(1 + 9i/D), rounded to the fraction width
   function automatic logic [CURVE_W-1:0] log_point(input int i);
      logic [63:0] l;
      logic [63:0] prod;
      l    = log2_q32(64'(LOG_DEPTH + 9 * i)) - log2_q32(64'(LOG_DEPTH));
      prod = (l >> 8) * 64'd1292913987;
      return CURVE_W'((prod + (64'd1 << (55 - FRAC_BITS))) >> (56 - FRAC_BITS));
   endfunction

   function automatic log_tab_type build_log_table();
      log_tab_type t;
      for (int i = 0; i <= LOG_DEPTH; i++) begin
         t[i] = log_point(i);
      end
      return t;
   endfunction

endpackage

// File: src/adsr_envelope_shaper_unit.sv
// ----------------------------------------------------------------------------
// adsr_envelope_shaper_unit
// Maps a phase word to an ADSR envelope level and the active segment.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction | word
//  req     | req_valid/ready, req_phase     | in        | phase, Q0.16
//  rsp     | rsp_valid/ready, rsp_level/seg | out       | level Q0.16, segment
//  csr     | csr_valid/ready, index, data   | in        | register write
//
//  One word per cycle enters while rsp is not stalled; the path runs through the
//  16-stage restoring divider and the 16-stage square-root pipeline in series.
//  Synchronous active-high reset clears valid bits and loads register defaults.
//  A stall at rsp freezes the whole pipeline; req_ready drops with it.
// ----------------------------------------------------------------------------
module adsr_envelope_shaper_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_phase,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_level,
   output logic [1:0]  rsp_segment,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_data
);
   import adsr_pkg::*;

   localparam int DIV_STAGES  = 16;
   localparam int SQRT_STAGES = 16;
   localparam logic [CURVE_W-1:0] ONE = CURVE_W'(1) << FRAC_BITS;
   localparam log_tab_type LOG_TAB = build_log_table();

   // configuration registers
   logic [15:0] sus_lvl_ff, wa_ff, wd_ff, ws_ff, wr_ff;
   logic [2:0]  sha_ff, shd_ff, shr_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sus_lvl_ff <= 16'hFFFF;
         wa_ff      <= 16'hFFFF;
         wd_ff      <= '0;
         ws_ff      <= '0;
         wr_ff      <= '0;
         sha_ff     <= SHAPE_LIN;
         shd_ff     <= SHAPE_NONE;
         shr_ff     <= SHAPE_NONE;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_SUSTAIN_LEVEL:  sus_lvl_ff <= csr_data;
            REG_ATTACK_WEIGHT:  wa_ff      <= csr_data;
            REG_DECAY_WEIGHT:   wd_ff      <= csr_data;
            REG_SUSTAIN_WEIGHT: ws_ff      <= csr_data;
            REG_RELEASE_WEIGHT: wr_ff      <= csr_data;
            REG_ATTACK_SHAPE:   sha_ff     <= csr_data[2:0];
            REG_DECAY_SHAPE:    shd_ff     <= csr_data[2:0];
            REG_RELEASE_SHAPE:  shr_ff     <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // effective weights and cumulative bounds
   logic [15:0] wa_eff, wd_eff, wr_eff;
   logic [17:0] wsum;
   logic [33:0] b1, b2, b3;
   logic        sum_zero;
   logic [CURVE_W-1:0] amp;

   always_comb begin
      wa_eff   = (sha_ff > SHAPE_SQRT) ? 16'd0 : wa_ff;
      wd_eff   = (shd_ff > SHAPE_SQRT || wa_eff == 16'd0) ? 16'd0 : wd_ff;
      wr_eff   = (shr_ff > SHAPE_SQRT) ? 16'd0 : wr_ff;
      wsum     = 18'(wa_eff) + 18'(wd_eff) + 18'(ws_ff) + 18'(wr_eff);
      b1       = {2'b0, wa_eff, 16'd0};
      b2       = {(18'(wa_eff) + 18'(wd_eff)), 16'd0};
      b3       = {(18'(wa_eff) + 18'(wd_eff) + 18'(ws_ff)), 16'd0};
      sum_zero = (wsum == 18'd0);
      amp      = (sus_lvl_ff == 16'hFFFF) ? ONE : CURVE_W'(sus_lvl_ff);
   end

   // global advance: move unless the output word is stalled
   logic en;
   logic out_vld_ff;
   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = en;

   // stage 1: phase times weight sum
   logic        s1_vld_ff;
   logic [33:0] s1_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_p_ff <= 34'(req_phase) * 34'(wsum);
      end
   end

   // divider pipeline; entry 0 is the segment select stage
   logic        dv_vld_ff [0:DIV_STAGES];
   logic [15:0] dv_rem_ff [0:DIV_STAGES];
   logic [15:0] dv_low_ff [0:DIV_STAGES];
   logic [15:0] dv_q_ff   [0:DIV_STAGES];
   logic [15:0] dv_w_ff   [0:DIV_STAGES];
   tag_type     dv_tag_ff [0:DIV_STAGES];

   // stage 2: pick segment, local numerator and weight
   tag_type     s2_tag_in;
   logic [33:0] s2_num_in;
   logic [15:0] s2_w_in;

   always_comb begin
      s2_tag_in = '{seg: SEG_SUSTAIN, shape: SHAPE_LIN};
      s2_num_in = '0;
      s2_w_in   = ws_ff;
      if (sum_zero) begin
         s2_tag_in = '{seg: SEG_SUSTAIN, shape: SHAPE_LIN};
      end else if (s1_p_ff < b1) begin
         s2_tag_in = '{seg: SEG_ATTACK, shape: sha_ff};
         s2_num_in = s1_p_ff;
         s2_w_in   = wa_eff;
      end else if (s1_p_ff < b2) begin
         s2_tag_in = '{seg: SEG_DECAY, shape: shd_ff};
         s2_num_in = s1_p_ff - b1;
         s2_w_in   = wd_eff;
      end else if (s1_p_ff < b3) begin
         s2_tag_in = '{seg: SEG_SUSTAIN, shape: SHAPE_LIN};
      end else begin
         s2_tag_in = '{seg: SEG_RELEASE, shape: shr_ff};
         s2_num_in = s1_p_ff - b3;
         s2_w_in   = wr_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff[0] <= 1'b0;
      end else if (en) begin
         dv_vld_ff[0] <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_rem_ff[0] <= s2_num_in[31:16];
         dv_low_ff[0] <= s2_num_in[15:0];
         dv_q_ff[0]   <= '0;
         dv_w_ff[0]   <= s2_w_in;
         dv_tag_ff[0] <= s2_tag_in;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
      logic [16:0] trial;
      logic        take;
      assign trial = {dv_rem_ff[j-1], dv_low_ff[j-1][15]};
      assign take  = (trial >= {1'b0, dv_w_ff[j-1]});

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[j] <= 1'b0;
         end else if (en) begin
            dv_vld_ff[j] <= dv_vld_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_rem_ff[j] <= take ? 16'(trial - {1'b0, dv_w_ff[j-1]}) : trial[15:0];
            dv_low_ff[j] <= {dv_low_ff[j-1][14:0], 1'b0};
            dv_q_ff[j]   <= {dv_q_ff[j-1][14:0], take};
            dv_w_ff[j]   <= dv_w_ff[j-1];
            dv_tag_ff[j] <= dv_tag_ff[j-1];
         end
      end
   end

   // stage A: square product and log table points
   logic               sa_vld_ff;
   logic [15:0]        sa_x_ff;
   logic [31:0]        sa_sq_ff;
   logic [CURVE_W-1:0] sa_y0_ff, sa_y1_ff;
   tag_type            sa_tag_ff;
   logic [LOG_IDX_W-1:0] lidx;

   assign lidx = dv_q_ff[DIV_STAGES][15 -: LOG_IDX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_vld_ff <= 1'b0;
      end else if (en) begin
         sa_vld_ff <= dv_vld_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_x_ff   <= dv_q_ff[DIV_STAGES];
         sa_sq_ff  <= 32'(dv_q_ff[DIV_STAGES]) * 32'(dv_q_ff[DIV_STAGES]);
         sa_y0_ff  <= LOG_TAB[{1'b0, lidx}];
         sa_y1_ff  <= LOG_TAB[{1'b0, lidx} + (LOG_IDX_W + 1)'(1)];
         sa_tag_ff <= dv_tag_ff[DIV_STAGES];
      end
   end

   // stage B: linear, square or interpolated log curve, capped at one
   logic [CURVE_W-1:0] sb_c_in;
   logic [CURVE_W-1:0] dy;
   logic [CURVE_W+7:0] dprod;

   always_comb begin
      dy    = (sa_y1_ff > sa_y0_ff) ? (sa_y1_ff - sa_y0_ff) : '0;
      dprod = (CURVE_W + 8)'(dy) * (CURVE_W + 8)'(sa_x_ff[15 - LOG_IDX_W:0]);
      case (sa_tag_ff.shape)
         SHAPE_SQR: sb_c_in = CURVE_W'(sa_sq_ff[31:16]);
         SHAPE_LOG: sb_c_in = sa_y0_ff + CURVE_W'(dprod >> (16 - LOG_IDX_W));
         default:   sb_c_in = CURVE_W'(sa_x_ff);
      endcase
      if (sb_c_in > ONE) sb_c_in = ONE;
   end

   // square-root pipeline; entry 0 is stage B
   logic               sq_vld_ff [0:SQRT_STAGES];
   logic [31:0]        sq_v_ff   [0:SQRT_STAGES];
   logic [31:0]        sq_r_ff   [0:SQRT_STAGES];
   logic [CURVE_W-1:0] sq_c_ff   [0:SQRT_STAGES];
   tag_type            sq_tag_ff [0:SQRT_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else if (en) begin
         sq_vld_ff[0] <= sa_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_v_ff[0]   <= {sa_x_ff, 16'd0};
         sq_r_ff[0]   <= '0;
         sq_c_ff[0]   <= sb_c_in;
         sq_tag_ff[0] <= sa_tag_ff;
      end
   end

   // digit-by-digit square root, one result bit per stage
   for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_sqrt
      localparam logic [31:0] BIT = 32'd1 << (32 - 2 * k);
      logic [31:0] cand;
      logic        take;
      assign cand = sq_r_ff[k-1] + BIT;
      assign take = (sq_v_ff[k-1] >= cand);

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else if (en) begin
            sq_vld_ff[k] <= sq_vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_v_ff[k]   <= take ? (sq_v_ff[k-1] - cand) : sq_v_ff[k-1];
            sq_r_ff[k]   <= take ? ((sq_r_ff[k-1] >> 1) + BIT) : (sq_r_ff[k-1] >> 1);
            sq_c_ff[k]   <= sq_c_ff[k-1];
            sq_tag_ff[k] <= sq_tag_ff[k-1];
         end
      end
   end

   // stage M: final curve and level product
   logic               sm_vld_ff;
   logic [17:0]        sm_prod_ff;
   logic [CURVE_W-1:0] sm_c_ff;
   tag_type            sm_tag_ff;
   logic [CURVE_W-1:0] c_fin, one_mc, mul_a;

   always_comb begin
      c_fin  = (sq_tag_ff[SQRT_STAGES].shape == SHAPE_SQRT)
               ? CURVE_W'(sq_r_ff[SQRT_STAGES][15:0]) : sq_c_ff[SQRT_STAGES];
      one_mc = ONE - c_fin;
      mul_a  = (sq_tag_ff[SQRT_STAGES].seg == SEG_DECAY) ? (ONE - amp) : amp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sm_vld_ff <= 1'b0;
      end else if (en) begin
         sm_vld_ff <= sq_vld_ff[SQRT_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sm_prod_ff <= 18'((34'(mul_a) * 34'(one_mc)) >> FRAC_BITS);
         sm_c_ff    <= c_fin;
         sm_tag_ff  <= sq_tag_ff[SQRT_STAGES];
      end
   end

   // output stage: combine per segment and saturate
   logic [15:0] out_lvl_ff;
   logic [1:0]  out_seg_ff;
   logic [18:0] lvl_in;

   always_comb begin
      case (sm_tag_ff.seg)
         SEG_ATTACK:  lvl_in = 19'(sm_c_ff);
         SEG_DECAY:   lvl_in = 19'(amp) + 19'(sm_prod_ff);
         SEG_RELEASE: lvl_in = 19'(sm_prod_ff);
         default:     lvl_in = 19'(amp);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= sm_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_lvl_ff <= (lvl_in > 19'd65535) ? 16'hFFFF : lvl_in[15:0];
         out_seg_ff <= sm_tag_ff.seg;
      end
   end

   assign rsp_valid   = out_vld_ff;
   assign rsp_level   = out_lvl_ff;
   assign rsp_segment = out_seg_ff;

   // a stalled output word blocks intake
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_ready) |-> !req_ready)
      else $error("intake open while output stalled");

   // an accepted word enters the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_vld_ff)
      else $error("accepted word lost at entry");

   // zero weight sum always reports sustain
   a_zero_sum: assert property (@(posedge clock) disable iff (reset)
      (dv_vld_ff[0] && $past(sum_zero) && $past(en) && $stable(wsum))
      |-> (dv_tag_ff[0].seg == SEG_SUSTAIN))
      else $error("zero weight sum left sustain");

endmodule

// File: verif/tb_adsr_envelope_shaper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adsr_envelope_shaper_unit
// Drives phase words through the envelope shaper under a series of register
// settings and checks every level and segment word against a local predictor
// or a fixed word. Directed rows come first, then random settings and phases.
// ----------------------------------------------------------------------------
module tb_adsr_envelope_shaper_unit;
   import adsr_pkg::*;

   localparam int          DRAIN_CYCLES = 45;
   localparam int          STALL_LIMIT  = 4000;
   localparam logic [63:0] UNITY        = 64'd1 << 16;

   typedef struct {
      logic [15:0] level;
      logic [1:0]  segment;
   } env_word_t;

   typedef struct {
      bit          fixed;
      logic [15:0] level;
      logic [1:0]  segment;
   } typed_word_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_phase;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_level;
   logic [1:0]  rsp_segment;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [15:0] csr_data;

   // local copy of the registers, starting from the reset values
   logic [15:0] sustain_lvl = 16'hFFFF;
   logic [15:0] weight_a    = 16'hFFFF;
   logic [15:0] weight_d    = 16'd0;
   logic [15:0] weight_s    = 16'd0;
   logic [15:0] weight_r    = 16'd0;
   logic [2:0]  shape_a     = SHAPE_LIN;
   logic [2:0]  shape_d     = SHAPE_NONE;
   logic [2:0]  shape_r     = SHAPE_NONE;

   logic [63:0] log_curve [0:256];
   env_word_t   envelope_q[$];
   typed_word_t typed_q[$];
   int          mismatches  = 0;
   int          words_in    = 0;
   int          words_out   = 0;
   int          stall_count = 0;
   bit          steady;

   adsr_envelope_shaper_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // log2 with 32 fraction bits, by repeated squaring
   function automatic logic [63:0] log2_fixed(input logic [63:0] n);
      int          k;
      logic [63:0] m;
      logic [63:0] frac;
      k    = 0;
      frac = '0;
      if (n == 0) n = 1;
      while (k < 62 && (n >> (k + 1)) != 0) k++;
      m = (k <= 30) ? (n << (30 - k)) : (n >> (k - 30));
      for (int i = 0; i < 32; i++) begin
         m    = (m * m) >> 30;
         frac = frac << 1;
         if (m >= (64'd2 << 30)) begin
            m    = m >> 1;
            frac = frac | 64'd1;
         end
      end
      return (64'(k) << 32) | frac;
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] shaped(input logic [2:0] sh, input logic [63:0] x);
      logic [63:0] y;
      logic [63:0] pos, ix, fr, y0, y1;
      case (sh)
         SHAPE_LIN: y = x;
         SHAPE_SQR: y = (x * x) >> 16;
         SHAPE_LOG: begin
            pos = x * 256;
            ix  = pos >> 16;
            fr  = pos & (UNITY - 1);
            if (ix >= 256) begin
               ix = 255;
               fr = UNITY - 1;
            end
            y0 = log_curve[ix];
            y1 = log_curve[ix + 1];
            y  = y0 + ((y1 > y0) ? (((y1 - y0) * fr) >> 16) : 64'd0);
         end
         default: y = root_floor(x << 16);
      endcase
      return (y > UNITY) ? UNITY : y;
   endfunction

   function automatic logic [63:0] frac_in_segment(input logic [63:0] num,
                                                   input logic [63:0] w);
      logic [63:0] x;
      if (w == 0) return 0;
      x = (num << 16) / (w << 16);
      return (x >= UNITY) ? UNITY - 1 : x;
   endfunction

   function automatic env_word_t envelope_of(input logic [15:0] phase);
      env_word_t   e;
      logic [63:0] amp, wa, wd, ws, wr, total, p, b1, b2, b3, lvl, c;
      amp = (sustain_lvl == 16'hFFFF) ? UNITY : 64'(sustain_lvl);
      wa  = weight_a;
      wd  = weight_d;
      ws  = weight_s;
      wr  = weight_r;
      if (shape_a > SHAPE_SQRT) wa = 0;
      if (shape_d > SHAPE_SQRT || wa == 0) wd = 0;
      if (shape_r > SHAPE_SQRT) wr = 0;
      total = wa + wd + ws + wr;
      if (total == 0) begin
         lvl       = amp;
         e.segment = SEG_SUSTAIN;
      end else begin
         p  = 64'(phase) * total;
         b1 = wa << 16;
         b2 = (wa + wd) << 16;
         b3 = (wa + wd + ws) << 16;
         if (p < b1) begin
            lvl       = shaped(shape_a, frac_in_segment(p, wa));
            e.segment = SEG_ATTACK;
         end else if (p < b2) begin
            c         = shaped(shape_d, frac_in_segment(p - b1, wd));
            lvl       = amp + (((UNITY - amp) * (UNITY - c)) >> 16);
            e.segment = SEG_DECAY;
         end else if (p < b3) begin
            lvl       = amp;
            e.segment = SEG_SUSTAIN;
         end else begin
            c         = shaped(shape_r, frac_in_segment(p - b3, wr));
            lvl       = (amp * (UNITY - c)) >> 16;
            e.segment = SEG_RELEASE;
         end
      end
      e.level = (lvl > 64'd65535) ? 16'hFFFF : lvl[15:0];
      return e;
   endfunction

   // build the log10(1+9x) points once
   initial begin
      logic [63:0] l;
      logic [63:0] prod;
      for (int i = 0; i <= 256; i++) begin
         l            = log2_fixed(64'(256 + 9 * i)) - log2_fixed(64'd256);
         prod         = (l >> 8) * 64'd1292913987;
         log_curve[i] = (prod + (64'd1 << 39)) >> 40;
      end
   end

   // random back-pressure on the result side
   always @(posedge clock) begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 21);
   end

   // track registers, predict on accept, compare on result, watch for hangs
   always @(posedge clock) begin
      env_word_t   want;
      typed_word_t typed;
      bit          moved;
      moved = 1'b0;
      if (!reset && csr_valid && csr_ready) begin
         moved = 1'b1;
         case (csr_index)
            REG_SUSTAIN_LEVEL:  sustain_lvl = csr_data;
            REG_ATTACK_WEIGHT:  weight_a    = csr_data;
            REG_DECAY_WEIGHT:   weight_d    = csr_data;
            REG_SUSTAIN_WEIGHT: weight_s    = csr_data;
            REG_RELEASE_WEIGHT: weight_r    = csr_data;
            REG_ATTACK_SHAPE:   shape_a     = csr_data[2:0];
            REG_DECAY_SHAPE:    shape_d     = csr_data[2:0];
            REG_RELEASE_SHAPE:  shape_r     = csr_data[2:0];
            default: ;
         endcase
      end
      if (!reset && rsp_valid && rsp_ready) begin
         moved = 1'b1;
         words_out++;
         if (envelope_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: level %0d segment %0d", rsp_level, rsp_segment);
         end else begin
            want = envelope_q.pop_front();
            if (rsp_level !== want.level || rsp_segment !== want.segment) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch word %0d: expected level %0d segment %0d, got %0d %0d",
                           words_out, want.level, want.segment, rsp_level, rsp_segment);
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         moved = 1'b1;
         words_in++;
         want  = envelope_of(req_phase);
         typed = typed_q.pop_front();
         if (typed.fixed) begin
            want.level   = typed.level;
            want.segment = typed.segment;
         end
         envelope_q = {envelope_q, want};
      end
      stall_count = moved ? 0 : stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("FAIL adsr_envelope_shaper_unit");
         $finish;
      end
   end

   task automatic send_phase(input logic [15:0] ph, input typed_word_t typed);
      // idle one cycle at a time with a 21 percent chance per cycle
      while (!steady && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      typed_q = {typed_q, typed};
      req_valid <= 1'b1;
      req_phase <= ph;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_reg(input logic [7:0] ix, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= ix;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // drop valid, wait out every pending word plus the pipeline depth
   task automatic settle();
      req_valid <= 1'b0;
      while (envelope_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [15:0] sl, input logic [15:0] wa,
                               input logic [15:0] wd, input logic [15:0] ws,
                               input logic [15:0] wr, input logic [15:0] sa,
                               input logic [15:0] sd, input logic [15:0] sr);
      settle();
      write_reg(REG_SUSTAIN_LEVEL, sl);
      write_reg(REG_ATTACK_WEIGHT, wa);
      write_reg(REG_DECAY_WEIGHT, wd);
      write_reg(REG_SUSTAIN_WEIGHT, ws);
      write_reg(REG_RELEASE_WEIGHT, wr);
      write_reg(REG_ATTACK_SHAPE, sa);
      write_reg(REG_DECAY_SHAPE, sd);
      write_reg(REG_RELEASE_SHAPE, sr);
      // an index past the register list must change nothing
      write_reg(8'($urandom_range(8, 255)), 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(4))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2:       return 16'($urandom_range(1, 255));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_phase();
      case ($urandom_range(9))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      typed_word_t plain;
      typed_word_t directed_rows [8];
      logic [15:0] pattern [8];
      logic [15:0] sweep [4];
      plain       = '{fixed: 1'b0, level: '0, segment: '0};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_phase   = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      steady      = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // after reset only a linear attack is live: level follows phase
      pattern = '{16'd0, 16'd1, 16'h5555, 16'h7FFF, 16'h8000, 16'hAAAA,
                  16'hFFFE, 16'hFFFF};
      foreach (pattern[i]) begin
         directed_rows[i] = '{fixed: 1'b1, level: pattern[i], segment: SEG_ATTACK};
         send_phase(pattern[i], directed_rows[i]);
      end

      // each curve over equal segments, then zero weight sum
      sweep = '{16'd0, 16'h3FFF, 16'h9000, 16'hFFFF};
      for (int sh = 0; sh <= 4; sh++) begin
         program_regs(16'h6000, 16'd1, 16'd1, 16'd1, 16'd1, 16'(sh), 16'(sh), 16'(sh));
         foreach (sweep[i]) send_phase(sweep[i], plain);
      end
      program_regs(16'h1234, 16'd0, 16'd0, 16'd0, 16'd0,
                   16'(SHAPE_LIN), 16'(SHAPE_LIN), 16'(SHAPE_LIN));
      send_phase(16'h4000, '{fixed: 1'b1, level: 16'h1234, segment: SEG_SUSTAIN});

      // random settings, extremes included, one quiet phase without idling
      for (int ph = 0; ph < 12; ph++) begin
         case (ph)
            0: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'(SHAPE_LOG), 16'(SHAPE_SQR), 16'(SHAPE_SQRT));
            1: program_regs(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            16'(SHAPE_SQRT), 16'(SHAPE_LOG), 16'(SHAPE_LOG));
            2: program_regs(16'h8000, 16'h1000, 16'hFFFF, 16'd0, 16'd1,
                            16'hFFFC, 16'(SHAPE_LIN), 16'(SHAPE_SQR));
            default: program_regs(($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom),
                                  pick_weight(), pick_weight(), pick_weight(),
                                  pick_weight(), 16'($urandom), 16'($urandom),
                                  16'($urandom));
         endcase
         steady = (ph == 4);
         repeat (48) send_phase(pick_phase(), plain);
         steady = 1'b0;
      end
      settle();

      $display("covered %0d phase words in, %0d envelope words out,", words_in, words_out);
      $display("reset state, every curve code, zero weight sum and 12 random settings");
      if (mismatches == 0 && envelope_q.size() == 0) begin
         $display("PASS adsr_envelope_shaper_unit");
      end else begin
         $display("FAIL adsr_envelope_shaper_unit");
      end
      $finish;
   end

endmodule
